// ----- rtl/rlmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rlmt_pkg;

  localparam int RUN_W   = 24;
  localparam int LUMI_W  = 16;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 9;

  localparam logic [LUMI_W-1:0] LUMI_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [RUN_W-1:0]  run;
    logic [LUMI_W-1:0] first;
    logic [LUMI_W-1:0] last;
  } entry_t;

  // Result of comparing one stored range against the held pair.
  typedef struct packed {
    logic run_eq;
    logic in_range;
    logic follows;
  } cmp_t;

endpackage

`default_nettype wire

// ----- rtl/rlmt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rlmt_in_if;
  import rlmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [RUN_W-1:0]  run_number;
  logic [LUMI_W-1:0] lumi_number;
  logic [LUMI_W-1:0] last_lumi;

  modport source(output valid, kind, run_number, lumi_number, last_lumi, input ready);
  modport sink(input valid, kind, run_number, lumi_number, last_lumi, output ready);
endinterface

interface rlmt_out_if;
  import rlmt_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic               overflow;
  logic [COUNT_W-1:0] entry_count;

  modport source(output valid, hit, overflow, entry_count, input ready);
  modport sink(input valid, hit, overflow, entry_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/rlmt_range_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rlmt_range_ram
  import rlmt_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/rlmt_match_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rlmt_match_unit
  import rlmt_pkg::*;
(
  input  wire entry_t            ent,
  input  wire logic [RUN_W-1:0]  run,
  input  wire logic [LUMI_W-1:0] lumi,
  output cmp_t                   cmp
);

  logic [LUMI_W-1:0] last_inc;

  assign last_inc     = ent.last + LUMI_W'(1);
  assign cmp.run_eq   = (ent.run == run);
  assign cmp.in_range = cmp.run_eq && (lumi >= ent.first) && (lumi <= ent.last);
  // A range that already ends at the top lumi cannot grow.
  assign cmp.follows  = (ent.last != LUMI_MAX) && (lumi == last_inc);

endmodule

`default_nettype wire

// ----- rtl/run_lumi_range_mask_table_unit.sv -----
// Channel | Dir | Handshake          | Beat contents
// in_ch   | in  | valid/ready        | kind, run_number, lumi_number, last_lumi
// out_ch  | out | valid/ready        | hit, overflow, entry_count
//
// Clear and insert go from accept via S_DONE to the registered result; add
// first reads the newest range in S_TOP (skipped when the table is empty).
// A query scans stored ranges in order in S_SCAN up to the first hit or the
// last range; the single read port of the range memory sets the scan's pace.
// One item is in work at a time; in_ch.ready is high only when idle.
// Reset (rst_n low, synchronous) empties the table; no memory clearing pass.
// A result that is not taken holds out_ch and stalls the next finished item.
`timescale 1ns / 1ps
`default_nettype none

module run_lumi_range_mask_table_unit
  import rlmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rlmt_in_if.sink   in_ch,
  rlmt_out_if.source out_ch
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [RUN_W-1:0]   run_r;
  logic [LUMI_W-1:0]  lumi_r;
  logic               res_hit_r, res_hit_nxt;
  logic               res_ovf_r, res_ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               in_accept;
  logic               full;
  logic               scan_last;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   top_idx;
  logic [CNT_W+COUNT_W-1:0] cnt_wide;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data;
  cmp_t               cmp;

  rlmt_range_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rlmt_match_unit u_match (
    .ent  (rd_data),
    .run  (run_r),
    .lumi (lumi_r),
    .cmp  (cmp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(TABLE_ENTRIES));
  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign top_idx     = cnt_m1[IDX_W-1:0];
  assign scan_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign cnt_wide    = {{COUNT_W{1'b0}}, cnt_r};

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.entry_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    res_hit_r   <= res_hit_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_hit_r   <= out_hit_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_count_r <= out_count_nxt;
    if (in_accept) begin
      run_r  <= in_ch.run_number;
      lumi_r <= in_ch.lumi_number;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    res_hit_nxt   = res_hit_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_ovf_nxt   = out_ovf_r;
    out_count_nxt = out_count_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[IDX_W-1:0];
    wr_data       = '{run: run_r, first: lumi_r, last: lumi_r};
    rd_addr       = idx_r + IDX_W'(1);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_hit_nxt = 1'b0;
          res_ovf_nxt = 1'b0;
          state_nxt   = S_DONE;
          case (in_ch.kind)
            KIND_CLEAR: begin
              cnt_nxt = '0;
            end
            KIND_INSERT: begin
              if (full) begin
                res_ovf_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_data = '{run: in_ch.run_number, first: in_ch.lumi_number,
                            last: in_ch.last_lumi};
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            KIND_ADD: begin
              if (cnt_r == '0) begin
                wr_en   = 1'b1;
                wr_data = '{run: in_ch.run_number, first: in_ch.lumi_number,
                            last: in_ch.lumi_number};
                cnt_nxt = CNT_W'(1);
              end else begin
                // Fetch the newest range to see whether this lumi extends it.
                rd_addr   = top_idx;
                state_nxt = S_TOP;
              end
            end
            default: begin
              if (cnt_r != '0) begin
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_TOP: begin
        state_nxt = S_DONE;
        if (cmp.run_eq && cmp.follows) begin
          wr_en   = 1'b1;
          wr_addr = top_idx;
          wr_data = '{run: rd_data.run, first: rd_data.first, last: lumi_r};
        end else if (full) begin
          res_ovf_nxt = 1'b1;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_SCAN: begin
        // One stored range is compared per cycle while the next one is read.
        if (cmp.in_range) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (scan_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_ovf_nxt   = res_ovf_r;
          out_count_nxt = cnt_wide[COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  localparam logic [CNT_W+COUNT_W-1:0] FULL_WIDE = (CNT_W + COUNT_W)'(TABLE_ENTRIES);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_count_r == FULL_WIDE[COUNT_W-1:0])
    else $error("overflow reported while table not full");

  a_hit_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ovf_r))
    else $error("hit and overflow on the same result");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CNT_W'(idx_r) < cnt_r)
    else $error("scan index beyond stored ranges");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.kind == KIND_CLEAR |=> cnt_r == '0)
    else $error("clear did not empty the table");

endmodule

`default_nettype wire
